>>> src/voxel_grid_accumulator_core_assert.svh
// Assertion shorthands for the voxel grid accumulator.
`ifndef VOXEL_GRID_ACCUMULATOR_CORE_ASSERT_SVH
`define VOXEL_GRID_ACCUMULATOR_CORE_ASSERT_SVH

// cond must never hold outside reset
`define VGACC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define VGACC_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/vgacc_pkg.sv
package vgacc_pkg;

  localparam int X_CELLS    = 32;
  localparam int Y_CELLS    = 32;
  localparam int Z_CELLS    = 32;
  localparam int CELL_TOTAL = X_CELLS * Y_CELLS * Z_CELLS;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);

  localparam int IDX_W = 15;
  localparam int VAL_W = 16;
  localparam int CRD_W = 24;
  localparam int PIT_W = 23;
  localparam int DEL_W = 17;
  localparam int CTR_W = 32;
  localparam int TOT_W = 31;
  localparam int CNT_W = 16;
  localparam int DIV_W = CRD_W + 1;
  localparam int QUO_W = DIV_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ADD   = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN  = 3'd0,
    REG_Y_ORIGIN  = 3'd1,
    REG_Z_ORIGIN  = 3'd2,
    REG_X_PITCH   = 3'd3,
    REG_Y_PITCH   = 3'd4,
    REG_Z_PITCH   = 3'd5,
    REG_THRESHOLD = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_QUO,
    F_MUL,
    F_SUM,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RMW,
    B_SCAN,
    B_SFIN,
    B_SOUT
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic                      oob;
    logic [ADDR_W-1:0]         addr;
    logic [VAL_W-1:0]          new_value;
    logic signed [DEL_W-1:0]   delta;
    logic [2:0][CTR_W-1:0]     cen;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

>>> src/vgacc_fifo.sv
module vgacc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  vgacc_pkg::job_t         push_job,
  input  logic                    pop,
  output vgacc_pkg::job_t         head_job,
  output vgacc_pkg::fifo_stat_t   stat
);
  import vgacc_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  assign head_job   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

>>> src/vgacc_front.sv
module vgacc_front (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic                                      clearing,
  output logic                                      busy,
  input  logic [1:0]                                in_op,
  input  logic signed [vgacc_pkg::CRD_W-1:0]        in_x_coord,
  input  logic signed [vgacc_pkg::CRD_W-1:0]        in_y_coord,
  input  logic signed [vgacc_pkg::CRD_W-1:0]        in_z_coord,
  input  logic [vgacc_pkg::VAL_W-1:0]               in_new_value,
  input  logic signed [vgacc_pkg::DEL_W-1:0]        in_delta,
  input  logic [2:0][vgacc_pkg::CRD_W-1:0]          origin,
  input  logic [2:0][vgacc_pkg::PIT_W-1:0]          pitch,
  input  logic                                      fifo_full,
  output logic                                      push,
  output vgacc_pkg::job_t                           push_job
);
  import vgacc_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);
  localparam int CELLS [3] = '{X_CELLS, Y_CELLS, Z_CELLS};

  front_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic accept;

  logic [DIV_W-1:0]               mag_r  [3];
  logic [PIT_W-1:0]               rem_r  [3];
  logic                           neg_r  [3];
  logic [PIT_W-1:0]               pit_r  [3];
  logic [CRD_W-1:0]               org_r  [3];
  logic signed [QUO_W-1:0]        q_r    [3];
  logic [CTR_W-1:0]               prod_r [3];
  job_t                           job_r;

  logic [CRD_W-1:0]               crd      [3];
  logic [DIV_W-1:0]               diff     [3];
  logic [PIT_W:0]                 trial    [3];
  logic                           ge       [3];
  logic signed [QUO_W-1:0]        q_fix    [3];
  logic signed [QUO_W+PIT_W:0]    prod_full[3];
  logic [CTR_W-1:0]               centre   [3];
  logic                           out_axis [3];
  logic [ADDR_W-1:0]              flat;

  assign crd[0] = in_x_coord;
  assign crd[1] = in_y_coord;
  assign crd[2] = in_z_coord;

  assign accept = start && (state_r == F_IDLE) && !clearing;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]  = {crd[a][CRD_W-1], crd[a]} - {origin[a][CRD_W-1], origin[a]};
      trial[a] = {rem_r[a], mag_r[a][DIV_W-1]};
      ge[a]    = (trial[a] >= {1'b0, pit_r[a]});
      // floor: negative with remainder rounds one further down
      if (neg_r[a])
        q_fix[a] = (rem_r[a] != '0) ? ~$signed({1'b0, mag_r[a]})
                                    : ~$signed({1'b0, mag_r[a]}) + QUO_W'(1);
      else
        q_fix[a] = $signed({1'b0, mag_r[a]});
      prod_full[a] = q_r[a] * $signed({1'b0, pit_r[a]});
      centre[a] = {{(CTR_W-CRD_W){org_r[a][CRD_W-1]}}, org_r[a]}
                + CTR_W'(pit_r[a] >> 1) + prod_r[a];
      out_axis[a] = q_r[a][QUO_W-1] || (q_r[a][DIV_W-1:0] >= DIV_W'(CELLS[a]));
    end
    flat = ADDR_W'(q_r[0][DIV_W-1:0])
         + ADDR_W'(X_CELLS) * ADDR_W'(q_r[1][DIV_W-1:0])
         + ADDR_W'(X_CELLS * Y_CELLS) * ADDR_W'(q_r[2][DIV_W-1:0]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (accept) state_nxt = (op_t'(in_op) == OP_SCAN) ? F_PUSH : F_DIV;
      F_DIV:  if (step_r == STEP_W'(DIV_W - 1)) state_nxt = F_QUO;
      F_QUO:  state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUM;
      F_SUM:  state_nxt = F_PUSH;
      F_PUSH: if (!fifo_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != F_IDLE) || clearing;
    push     = (state_r == F_PUSH) && !fifo_full;
    push_job = job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          step_r          <= '0;
          job_r.op        <= op_t'(in_op);
          job_r.oob       <= 1'b0;
          job_r.addr      <= '0;
          job_r.new_value <= in_new_value;
          job_r.delta     <= in_delta;
          job_r.cen       <= '0;
          for (int a = 0; a < 3; a++) begin
            neg_r[a] <= diff[a][DIV_W-1];
            mag_r[a] <= diff[a][DIV_W-1] ? (~diff[a] + DIV_W'(1)) : diff[a];
            rem_r[a] <= '0;
            pit_r[a] <= (pitch[a] == '0) ? PIT_W'(1) : pitch[a];
            org_r[a] <= origin[a];
          end
        end
      end
      F_DIV: begin
        step_r <= step_r + STEP_W'(1);
        for (int a = 0; a < 3; a++) begin
          rem_r[a] <= ge[a] ? PIT_W'(trial[a] - {1'b0, pit_r[a]}) : trial[a][PIT_W-1:0];
          mag_r[a] <= {mag_r[a][DIV_W-2:0], ge[a]};
        end
      end
      F_QUO: for (int a = 0; a < 3; a++) q_r[a] <= q_fix[a];
      F_MUL: for (int a = 0; a < 3; a++) prod_r[a] <= prod_full[a][CTR_W-1:0];
      F_SUM: begin
        job_r.oob  <= out_axis[0] || out_axis[1] || out_axis[2];
        job_r.addr <= flat;
        for (int a = 0; a < 3; a++) job_r.cen[a] <= centre[a];
      end
      default: ;
    endcase
  end

endmodule

>>> src/vgacc_back.sv
module vgacc_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vgacc_pkg::job_t                      head_job,
  input  vgacc_pkg::fifo_stat_t                fstat,
  output logic                                 pop,
  input  logic [vgacc_pkg::VAL_W-1:0]          threshold,
  output vgacc_pkg::back_stat_t                bstat,
  output logic                                 out_strobe,
  output logic                                 out_status,
  output logic [vgacc_pkg::IDX_W-1:0]          out_cell_index,
  output logic [vgacc_pkg::VAL_W-1:0]          out_cell_value,
  output logic signed [vgacc_pkg::CTR_W-1:0]   out_centre_x,
  output logic signed [vgacc_pkg::CTR_W-1:0]   out_centre_y,
  output logic signed [vgacc_pkg::CTR_W-1:0]   out_centre_z,
  output logic [vgacc_pkg::IDX_W-1:0]          out_min_index,
  output logic [vgacc_pkg::VAL_W-1:0]          out_min_value,
  output logic [vgacc_pkg::TOT_W-1:0]          out_value_total,
  output logic [vgacc_pkg::CNT_W-1:0]          out_empty_count,
  output logic [vgacc_pkg::CNT_W-1:0]          out_above_count
);
  import vgacc_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELL_TOTAL - 1);

  back_state_t state_r, state_nxt;
  logic [VAL_W-1:0]  mem [CELL_TOTAL];
  logic [VAL_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] scan_cnt_r;
  logic              pv_r;
  logic [ADDR_W-1:0] pidx_r;
  job_t              cur_r;

  logic [VAL_W-1:0]  max_r, min_r;
  logic [ADDR_W-1:0] maxi_r, mini_r;
  logic [TOT_W-1:0]  total_r;
  logic [CNT_W-1:0]  empty_r, above_r;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [VAL_W-1:0]  upd_val;
  logic signed [VAL_W+2:0] add_sum;
  logic [TOT_W:0]    tot_sum;
  logic              emit_oob, emit_rmw, emit_scan;

  always_comb begin
    add_sum = $signed({3'b000, rd_data_r}) + (VAL_W+3)'(cur_r.delta);
    case (cur_r.op)
      OP_WRITE: upd_val = cur_r.new_value;
      OP_ADD: begin
        if (add_sum < 0)                           upd_val = '0;
        else if (add_sum > $signed((VAL_W+3)'(16'hFFFF))) upd_val = '1;
        else                                       upd_val = add_sum[VAL_W-1:0];
      end
      default: upd_val = rd_data_r;
    endcase
    tot_sum = {1'b0, total_r} + (TOT_W+1)'(rd_data_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_cnt_r == LAST) state_nxt = B_IDLE;
      B_IDLE: begin
        if (!fstat.empty) begin
          if (head_job.op == OP_SCAN) state_nxt = B_SCAN;
          else if (!head_job.oob)     state_nxt = B_RMW;
        end
      end
      B_RMW:  state_nxt = B_IDLE;
      B_SCAN: if (scan_cnt_r == LAST) state_nxt = B_SFIN;
      B_SFIN: state_nxt = B_SOUT;
      B_SOUT: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state_r == B_IDLE) && !fstat.empty;
    emit_oob  = pop && (head_job.op != OP_SCAN) && head_job.oob;
    emit_rmw  = (state_r == B_RMW);
    emit_scan = (state_r == B_SOUT);
    bstat.clearing = (state_r == B_CLEAR);
    mem_we    = (state_r == B_CLEAR) || emit_rmw;
    mem_waddr = (state_r == B_CLEAR) ? clr_cnt_r : cur_r.addr;
    mem_wdata = (state_r == B_CLEAR) ? '0 : upd_val;
    mem_re    = pop || (state_r == B_SCAN);
    mem_raddr = (state_r == B_SCAN) ? scan_cnt_r : head_job.addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      clr_cnt_r  <= '0;
      pv_r       <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= emit_oob || emit_rmw || emit_scan;
      if (state_r == B_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      pv_r <= (state_r == B_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r      <= head_job;
      scan_cnt_r <= '0;
      total_r    <= '0;
      empty_r    <= '0;
      above_r    <= '0;
    end
    if (state_r == B_SCAN) begin
      scan_cnt_r <= scan_cnt_r + ADDR_W'(1);
      pidx_r     <= scan_cnt_r;
    end
    if (pv_r) begin
      if (pidx_r == '0 || rd_data_r > max_r) begin
        max_r  <= rd_data_r;
        maxi_r <= pidx_r;
      end
      if (pidx_r == '0 || rd_data_r < min_r) begin
        min_r  <= rd_data_r;
        mini_r <= pidx_r;
      end
      total_r <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
      if (rd_data_r == '0 && empty_r != '1) empty_r <= empty_r + CNT_W'(1);
      if (rd_data_r > threshold && above_r != '1) above_r <= above_r + CNT_W'(1);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_oob || emit_rmw || emit_scan) begin
      out_status      <= emit_oob;
      out_cell_index  <= '0;
      out_cell_value  <= '0;
      out_centre_x    <= '0;
      out_centre_y    <= '0;
      out_centre_z    <= '0;
      out_min_index   <= '0;
      out_min_value   <= '0;
      out_value_total <= '0;
      out_empty_count <= '0;
      out_above_count <= '0;
      if (emit_oob) begin
        out_centre_x <= head_job.cen[0];
        out_centre_y <= head_job.cen[1];
        out_centre_z <= head_job.cen[2];
      end
      if (emit_rmw) begin
        out_cell_index <= IDX_W'(cur_r.addr);
        out_cell_value <= upd_val;
        out_centre_x   <= cur_r.cen[0];
        out_centre_y   <= cur_r.cen[1];
        out_centre_z   <= cur_r.cen[2];
      end
      if (emit_scan) begin
        out_cell_index  <= IDX_W'(maxi_r);
        out_cell_value  <= max_r;
        out_min_index   <= IDX_W'(mini_r);
        out_min_value   <= min_r;
        out_value_total <= total_r;
        out_empty_count <= empty_r;
        out_above_count <= above_r;
      end
    end
  end

endmodule

>>> src/voxel_grid_accumulator_core.sv
// Voxel grid accumulator: 32x32x32 grid of 16-bit counts. After reset the
// grid is cleared in one pass, busy high throughout; config writes are
// taken during that pass. A point operation runs through the front end in
// order: accept, the bit-per-cycle dividers run on all three axes together,
// quotient fix, multiply, centre sum, and hand the transaction to the queue
// (waiting while the queue is full). The back end then reads the cell as it
// pops the transaction and writes it back in its read-modify-write state.
// busy drops once the front end has queued the transaction, so a new point
// is taken only after the last one is queued. A scan walks the whole memory
// in the back end, one cell per cycle through its single read port;
// meanwhile the two-entry queue fills and the front end holds busy high
// until a slot frees. Each result is shown for exactly one cycle with
// out_strobe; the receiver cannot stall and there is no backpressure on the
// result side. cfg_ready is always high.
module voxel_grid_accumulator_core (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic [1:0]                                 in_op,
  input  logic signed [vgacc_pkg::CRD_W-1:0]         in_x_coord,
  input  logic signed [vgacc_pkg::CRD_W-1:0]         in_y_coord,
  input  logic signed [vgacc_pkg::CRD_W-1:0]         in_z_coord,
  input  logic [vgacc_pkg::VAL_W-1:0]                in_new_value,
  input  logic signed [vgacc_pkg::DEL_W-1:0]         in_delta,
  output logic                                       out_strobe,
  output logic                                       out_status,
  output logic [vgacc_pkg::IDX_W-1:0]                out_cell_index,
  output logic [vgacc_pkg::VAL_W-1:0]                out_cell_value,
  output logic signed [vgacc_pkg::CTR_W-1:0]         out_centre_x,
  output logic signed [vgacc_pkg::CTR_W-1:0]         out_centre_y,
  output logic signed [vgacc_pkg::CTR_W-1:0]         out_centre_z,
  output logic [vgacc_pkg::IDX_W-1:0]                out_min_index,
  output logic [vgacc_pkg::VAL_W-1:0]                out_min_value,
  output logic [vgacc_pkg::TOT_W-1:0]                out_value_total,
  output logic [vgacc_pkg::CNT_W-1:0]                out_empty_count,
  output logic [vgacc_pkg::CNT_W-1:0]                out_above_count,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [vgacc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [vgacc_pkg::CRD_W-1:0]                cfg_data
);
  import vgacc_pkg::*;

  logic [2:0][CRD_W-1:0] origin_r;
  logic [2:0][PIT_W-1:0] pitch_r;
  logic [VAL_W-1:0]      thresh_r;

  logic       fifo_push, fifo_pop;
  job_t       push_job, head_job;
  fifo_stat_t fstat;
  back_stat_t bstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      pitch_r  <= {3{PIT_W'(256)}};
      thresh_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_ORIGIN:  origin_r[0] <= cfg_data;
        REG_Y_ORIGIN:  origin_r[1] <= cfg_data;
        REG_Z_ORIGIN:  origin_r[2] <= cfg_data;
        REG_X_PITCH:   pitch_r[0]  <= cfg_data[PIT_W-1:0];
        REG_Y_PITCH:   pitch_r[1]  <= cfg_data[PIT_W-1:0];
        REG_Z_PITCH:   pitch_r[2]  <= cfg_data[PIT_W-1:0];
        REG_THRESHOLD: thresh_r    <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  vgacc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .clearing     (bstat.clearing),
    .busy         (busy),
    .in_op        (in_op),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .in_z_coord   (in_z_coord),
    .in_new_value (in_new_value),
    .in_delta     (in_delta),
    .origin       (origin_r),
    .pitch        (pitch_r),
    .fifo_full    (fstat.full),
    .push         (fifo_push),
    .push_job     (push_job)
  );

  vgacc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_job (push_job),
    .pop      (fifo_pop),
    .head_job (head_job),
    .stat     (fstat)
  );

  vgacc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .fstat           (fstat),
    .pop             (fifo_pop),
    .threshold       (thresh_r),
    .bstat           (bstat),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_cell_index  (out_cell_index),
    .out_cell_value  (out_cell_value),
    .out_centre_x    (out_centre_x),
    .out_centre_y    (out_centre_y),
    .out_centre_z    (out_centre_z),
    .out_min_index   (out_min_index),
    .out_min_value   (out_min_value),
    .out_value_total (out_value_total),
    .out_empty_count (out_empty_count),
    .out_above_count (out_above_count)
  );

`include "voxel_grid_accumulator_core_assert.svh"

  `VGACC_NEVER(a_no_result_in_clear, bstat.clearing && out_strobe, "result during clear")
  `VGACC_NEVER(a_queue_overflow, fifo_push && fstat.full, "queue overflow")
  `VGACC_IMPLY(a_oob_no_cell, out_strobe && out_status, out_cell_index == '0 && out_cell_value == '0 && out_value_total == '0, "outside point carries cell data")

endmodule
